### sv/asmc_pkg.sv
`default_nettype none
package asmc_pkg;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_MOD,
    OP_SQRT
  } unit_op_t;

  typedef struct packed {
    logic     start;
    unit_op_t op;
  } unit_req_t;

  localparam int unsigned IndexWidth = 3;

  localparam logic [IndexWidth-1:0] REG_SURFACE_SLOPE = 3'd0;
  localparam logic [IndexWidth-1:0] REG_LINEAR_GAIN   = 3'd1;
  localparam logic [IndexWidth-1:0] REG_ADAPT_STEP    = 3'd2;
  localparam logic [IndexWidth-1:0] REG_GAIN_FLOOR    = 3'd3;
  localparam logic [IndexWidth-1:0] REG_SURFACE_BAND  = 3'd4;
  localparam logic [IndexWidth-1:0] REG_WRAP_ENABLE   = 3'd5;
  localparam logic [IndexWidth-1:0] REG_INPUT_LOW     = 3'd6;
  localparam logic [IndexWidth-1:0] REG_INPUT_HIGH    = 3'd7;

  localparam logic [30:0] SLOPE_RESET = 31'd65536;

endpackage
`default_nettype wire

### sv/asmc_unit.sv
`default_nettype none
// Shared bit-serial unit: shift-add multiply, restoring remainder and
// digit-by-digit square root, one result bit per cycle through one adder.
module asmc_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire asmc_pkg::unit_req_t req,
  input  wire logic [63:0]       a,
  input  wire logic [47:0]       b,
  output logic                   done,
  output logic [79:0]            res
);

  asmc_pkg::unit_op_t op;
  logic [49:0] hi;
  logic [63:0] lo;
  logic [47:0] m;
  logic [31:0] q;
  logic [5:0]  cnt;
  logic        busy;

  logic [33:0] mod_t;
  logic [35:0] sqrt_t;
  logic [49:0] x;
  logic [49:0] y;
  logic        sub;
  logic [49:0] sum;

  always_comb begin
    mod_t  = {hi[32:0], lo[63]};
    sqrt_t = {hi[33:0], lo[63:62]};
    x   = hi;
    y   = '0;
    sub = 1'b0;
    case (op)
      asmc_pkg::OP_MUL: begin
        x = hi;
        y = lo[0] ? {2'b0, m} : 50'd0;
      end
      asmc_pkg::OP_MOD: begin
        x   = {16'b0, mod_t};
        y   = {17'b0, m[32:0]};
        sub = 1'b1;
      end
      asmc_pkg::OP_SQRT: begin
        x   = {14'b0, sqrt_t};
        y   = {16'b0, q, 2'b01};
        sub = 1'b1;
      end
      default: begin
        x = hi;
      end
    endcase
    sum = x + (sub ? ~y : y) + {49'b0, sub};
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      op   <= asmc_pkg::OP_MUL;
    end else if (req.start) begin
      op   <= req.op;
      m    <= b;
      hi   <= '0;
      q    <= '0;
      busy <= 1'b1;
      cnt  <= (req.op == asmc_pkg::OP_MOD) ? 6'd33 : 6'd32;
      case (req.op)
        asmc_pkg::OP_MUL:  lo <= {32'b0, a[31:0]};
        asmc_pkg::OP_MOD:  lo <= {a[32:0], 31'b0};
        default:           lo <= a;
      endcase
    end else if (busy) begin
      case (op)
        asmc_pkg::OP_MUL: begin
          hi <= {1'b0, sum[49:1]};
          lo <= {32'b0, sum[0], lo[31:1]};
        end
        asmc_pkg::OP_MOD: begin
          hi <= sum[49] ? {16'b0, mod_t} : sum;
          lo <= {lo[62:0], 1'b0};
        end
        default: begin
          hi <= sum[49] ? {14'b0, sqrt_t} : sum;
          q  <= {q[30:0], ~sum[49]};
          lo <= {lo[61:0], 2'b0};
        end
      endcase
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    case (op)
      asmc_pkg::OP_MUL: res = {hi[47:0], lo[31:0]};
      asmc_pkg::OP_MOD: res = {47'b0, hi[32:0]};
      default:          res = {48'b0, q};
    endcase
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !busy) else $error("unit started while busy");
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("unit done while still busy");
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != 6'd0) else $error("unit busy with zero count");
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("unit done without work");
`endif

endmodule
`default_nettype wire

### sv/adaptive_sliding_mode_controller_top.sv
`default_nettype none
// Each accepted word runs through the shared bit-serial unit in turn: three multiplies,
// a square root and a remainder (fold only), with the other steps in their own states.
// A new word is accepted only once the previous result has been loaded into the output
// register, so a result word that waits on out_ready also holds off the input.
// Reset (rst, synchronous, active high) restores the register defaults and
// clears the kept error, the adaptive gain and out_valid and returns the block to idle.
module adaptive_sliding_mode_controller_top (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic signed [31:0]              target,
  input  wire logic signed [31:0]              measured,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic signed [31:0]                   drive,
  output logic signed [31:0]                   tracking_error,
  input  wire logic                            cfg_write,
  input  wire logic [asmc_pkg::IndexWidth-1:0] cfg_index,
  input  wire logic [31:0]                     cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_WRAP, S_MOD, S_ESAT, S_SURF, S_GAIN, S_ROOT, S_KMUL, S_LMUL, S_FINAL
  } state_t;

  // Saturate a wide signed value to the 32-bit output range.
  function automatic logic [31:0] sat32(input logic signed [42:0] v);
    logic [31:0] r;
    begin
      if (v > 43'sh0007FFFFFFF) r = 32'h7FFF_FFFF;
      else if (v < -43'sh00080000000) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
    end
  endfunction

  // Products are capped at 2^40 so the final sum cannot wrap.
  function automatic logic [40:0] clamp40(input logic [63:0] v);
    begin
      return (v > 64'h100_0000_0000) ? 41'h100_0000_0000 : v[40:0];
    end
  endfunction

  state_t state;

  // Configuration registers.
  logic [30:0]        surface_slope;
  logic [30:0]        linear_gain;
  logic [30:0]        adapt_step;
  logic [30:0]        gain_floor;
  logic [30:0]        surface_band;
  logic               wrap_enable;
  logic signed [31:0] input_low;
  logic signed [31:0] input_high;

  // Controller state kept across words.
  logic signed [31:0] previous_error;
  logic signed [31:0] adaptive_gain;

  // Per-word working registers.
  logic signed [32:0] err_raw;
  logic [32:0]        err_mag;
  logic signed [33:0] err_wide;
  logic signed [32:0] delta;
  logic               err_neg;
  logic [47:0]        surf_mag;
  logic               surf_neg;
  logic               surf_nz;
  logic [40:0]        root_term;
  logic [40:0]        lin_term;
  logic [31:0]        err_out;

  asmc_pkg::unit_req_t req;
  logic [63:0]         unit_a;
  logic [47:0]         unit_b;
  logic                unit_done;
  logic [79:0]         unit_res;

  asmc_unit u_unit (
    .clk  (clk),
    .rst  (rst),
    .req  (req),
    .a    (unit_a),
    .b    (unit_b),
    .done (unit_done),
    .res  (unit_res)
  );

  // Combinational helpers for the step-by-step datapath.
  logic signed [32:0] err_in;
  logic signed [32:0] span;
  logic               span_pos;
  logic [32:0]        folded;
  logic [31:0]        err_sat;
  logic [31:0]        err_sat_mag;
  logic signed [48:0] surf;
  logic [47:0]        t1_wide;
  logic               gain_high;
  logic signed [32:0] gain_sum;
  logic [31:0]        gain_new;
  logic [31:0]        gain_mag;
  logic signed [42:0] total;
  logic signed [42:0] term_a;
  logic signed [42:0] term_b;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    err_in   = {target[31], target} - {measured[31], measured};
    span     = {input_high[31], input_high} - {input_low[31], input_low};
    span_pos = !span[32] && (span != 33'sd0);
    folded   = span - unit_res[32:0];
    err_sat  = sat32({{9{err_wide[33]}}, err_wide});
    err_sat_mag = err_sat[31] ? (32'd0 - err_sat) : err_sat;
    t1_wide  = unit_res[63:16];
    surf     = (err_neg ? -$signed({2'b0, t1_wide[46:0]}) : $signed({2'b0, t1_wide[46:0]}))
               + {{16{delta[32]}}, delta};
    gain_high = adaptive_gain > $signed({1'b0, gain_floor});
    if (gain_high) begin
      if (surf_mag > {17'b0, surface_band}) begin
        gain_sum = {adaptive_gain[31], adaptive_gain} + $signed({2'b0, adapt_step});
      end else if (surf_mag < {17'b0, surface_band}) begin
        gain_sum = {adaptive_gain[31], adaptive_gain} - $signed({2'b0, adapt_step});
      end else begin
        gain_sum = {adaptive_gain[31], adaptive_gain};
      end
    end else begin
      gain_sum = {adaptive_gain[31], adaptive_gain} + $signed({2'b0, gain_floor});
    end
    gain_new = sat32({{10{gain_sum[32]}}, gain_sum});
    gain_mag = adaptive_gain[31] ? (32'd0 - adaptive_gain) : adaptive_gain;
    term_a   = (adaptive_gain[31] != surf_neg) ? -$signed({2'b0, root_term})
                                               : $signed({2'b0, root_term});
    term_b   = surf_neg ? -$signed({2'b0, lin_term}) : $signed({2'b0, lin_term});
    total    = surf_nz ? (term_a + term_b) : 43'sd0;
  end

  // Unit requests are issued from the state in which the operands are ready.
  always_comb begin
    req.start = 1'b0;
    req.op    = asmc_pkg::OP_MUL;
    unit_a    = '0;
    unit_b    = '0;
    case (state)
      S_WRAP: begin
        req.op = asmc_pkg::OP_MOD;
        unit_a = {31'b0, err_mag};
        unit_b = {15'b0, span};
        req.start = wrap_enable && span_pos &&
                    ({err_mag, 1'b0} > {1'b0, span});
      end
      S_ESAT: begin
        req.start = 1'b1;
        unit_a = {32'b0, err_sat_mag};
        unit_b = {17'b0, surface_slope};
      end
      S_GAIN: begin
        req.start = 1'b1;
        req.op = asmc_pkg::OP_SQRT;
        unit_a = {surf_mag, 16'b0};
      end
      S_ROOT: begin
        req.start = unit_done;
        unit_a = {32'b0, gain_mag};
        unit_b = {16'b0, unit_res[31:0]};
      end
      S_KMUL: begin
        req.start = unit_done;
        unit_a = {33'b0, linear_gain};
        unit_b = surf_mag;
      end
      default: begin
        req.start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      surface_slope  <= asmc_pkg::SLOPE_RESET;
      linear_gain    <= '0;
      adapt_step     <= '0;
      gain_floor     <= '0;
      surface_band   <= '0;
      wrap_enable    <= 1'b0;
      input_low      <= '0;
      input_high     <= '0;
      previous_error <= '0;
      adaptive_gain  <= '0;
    end else begin
      // The final state reloads the result word itself, so only clear it elsewhere.
      if (out_valid && out_ready && state != S_FINAL) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        // Any register write restarts the adaptation from zero.
        previous_error <= '0;
        adaptive_gain  <= '0;
        case (cfg_index)
          asmc_pkg::REG_SURFACE_SLOPE: surface_slope <= cfg_data[30:0];
          asmc_pkg::REG_LINEAR_GAIN:   linear_gain   <= cfg_data[30:0];
          asmc_pkg::REG_ADAPT_STEP:    adapt_step    <= cfg_data[30:0];
          asmc_pkg::REG_GAIN_FLOOR:    gain_floor    <= cfg_data[30:0];
          asmc_pkg::REG_SURFACE_BAND:  surface_band  <= cfg_data[30:0];
          asmc_pkg::REG_WRAP_ENABLE:   wrap_enable   <= cfg_data[0];
          asmc_pkg::REG_INPUT_LOW:     input_low     <= cfg_data;
          asmc_pkg::REG_INPUT_HIGH:    input_high    <= cfg_data;
          default:                     wrap_enable   <= wrap_enable;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            err_raw <= err_in;
            err_mag <= err_in[32] ? (33'd0 - err_in) : err_in;
            state   <= S_WRAP;
          end
        end
        S_WRAP: begin
          // Fold only when the error is more than half the span away.
          if (req.start) begin
            state <= S_MOD;
          end else begin
            err_wide <= {err_raw[32], err_raw};
            state    <= S_ESAT;
          end
        end
        S_MOD: begin
          if (unit_done) begin
            // folded = span * (|e| / span + 1) - |e| = span - (|e| mod span)
            err_wide <= (!err_raw[32] && err_raw != 33'sd0) ? -$signed({1'b0, folded})
                                                            : $signed({1'b0, folded});
            state <= S_ESAT;
          end
        end
        S_ESAT: begin
          delta          <= $signed({err_sat[31], err_sat}) -
                            $signed({previous_error[31], previous_error});
          previous_error <= err_sat;
          err_out        <= err_sat;
          err_neg        <= err_sat[31];
          state          <= S_SURF;
        end
        S_SURF: begin
          if (unit_done) begin
            surf_neg <= surf[48];
            surf_mag <= surf[48] ? 48'(-surf) : surf[47:0];
            surf_nz  <= (surf != 49'sd0);
            state    <= S_GAIN;
          end
        end
        S_GAIN: begin
          adaptive_gain <= gain_new;
          state         <= S_ROOT;
        end
        S_ROOT: begin
          if (unit_done) begin
            state <= S_KMUL;
          end
        end
        S_KMUL: begin
          if (unit_done) begin
            root_term <= clamp40({16'b0, unit_res[63:16]});
            state     <= S_LMUL;
          end
        end
        S_LMUL: begin
          if (unit_done) begin
            lin_term <= clamp40(unit_res[79:16]);
            state    <= S_FINAL;
          end
        end
        S_FINAL: begin
          if (!out_valid || out_ready) begin
            drive          <= sat32(total);
            tracking_error <= err_out;
            out_valid      <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result word dropped");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !req.start) else $error("unit started while idle");
  a_final_to_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_FINAL && out_ready |=> state == S_IDLE && out_valid)
    else $error("result word not produced");
`endif

endmodule
`default_nettype wire

### tb/sv/tb_adaptive_sliding_mode_controller_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_adaptive_sliding_mode_controller_top;

  // The block takes one word per tick and finishes each word before it takes the
  // next, so the settle time at phase changes and at the end covers a whole word.
  localparam int SettleCycles = 260;
  localparam int HoldCycles   = 900;
  localparam int CycleLimit   = 2000000;
  localparam longint unsigned OutputCap = 64'h100_0000_0000;

  typedef struct {
    logic signed [31:0] target;
    logic signed [31:0] measured;
  } tick_word_t;

  typedef struct {
    logic signed [31:0] drive;
    logic signed [31:0] tracking_error;
  } control_word_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic signed [31:0]              target = '0;
  logic signed [31:0]              measured = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic signed [31:0]              drive;
  logic signed [31:0]              tracking_error;
  logic                            cfg_write = 1'b0;
  logic [asmc_pkg::IndexWidth-1:0] cfg_index = '0;
  logic [31:0]                     cfg_data = '0;

  adaptive_sliding_mode_controller_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .target(target),
    .measured(measured),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .drive(drive),
    .tracking_error(tracking_error),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Local copy of the controller settings and its two words of state.
  longint unsigned slope_q, lin_gain_q, step_q, floor_q, band_q;
  bit              wrap_on;
  longint          range_low, range_high;
  longint          kept_error, gain_acc;

  tick_word_t      pending_ticks[$];
  control_word_t   expected_words[$];
  int              fail_count = 0;
  bit              hold_go = 1'b0;
  bit              hold_done = 1'b0;
  int              hold_count = 0;
  int              cycle_count = 0;

  task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                 input logic signed [31:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  function automatic longint sat_word(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? longint'(-v) : longint'(v);
  endfunction

  // Floor square root, one result bit resolved per step.
  function automatic longint unsigned floor_root(input longint unsigned x);
    longint unsigned rem, root, bitpos;
    rem = x;
    root = 0;
    bitpos = 64'd1 << 62;
    while (bitpos > rem) bitpos >>= 2;
    while (bitpos != 0) begin
      if (rem >= root + bitpos) begin
        rem -= root + bitpos;
        root = (root >> 1) + bitpos;
      end else begin
        root >>= 1;
      end
      bitpos >>= 2;
    end
    return root;
  endfunction

  function automatic control_word_t next_control(input tick_word_t w);
    control_word_t   r;
    longint          err, span, delta, surf, gain, pterm, lterm, total;
    longint unsigned err_mag, surf_mag, folds, folded, scaled, root, root_term, lin_term;
    err = longint'(w.target) - longint'(w.measured);
    span = range_high - range_low;
    if (wrap_on && span > 0) begin
      err_mag = magnitude(err);
      // Fold only past half a span; the fold count rounds the magnitude up.
      if (2 * err_mag > longint'(span)) begin
        folds = err_mag / longint'(span) + 1;
        folded = longint'(span) * folds - err_mag;
        err = (err > 0) ? -longint'(folded) : longint'(folded);
      end
    end
    err = sat_word(err);
    delta = err - kept_error;
    kept_error = err;
    err_mag = magnitude(err);
    scaled = (slope_q * err_mag) >> 16;
    surf = ((err < 0) ? -longint'(scaled) : longint'(scaled)) + delta;
    surf_mag = magnitude(surf);
    gain = gain_acc;
    if (gain > longint'(floor_q)) begin
      if (surf_mag > band_q) gain += longint'(step_q);
      else if (surf_mag < band_q) gain -= longint'(step_q);
    end else begin
      gain += longint'(floor_q);
    end
    gain = sat_word(gain);
    gain_acc = gain;
    root = floor_root(surf_mag << 16);
    root_term = (magnitude(gain) * root) >> 16;
    if (root_term > OutputCap) root_term = OutputCap;
    lin_term = lin_gain_q * (surf_mag >> 16) + ((lin_gain_q * (surf_mag & 64'hFFFF)) >> 16);
    if (lin_term > OutputCap) lin_term = OutputCap;
    total = 0;
    if (surf != 0) begin
      pterm = longint'(root_term);
      lterm = longint'(lin_term);
      if ((gain < 0) != (surf < 0)) pterm = -pterm;
      if (surf < 0) lterm = -lterm;
      total = pterm + lterm;
    end
    r.drive = 32'(sat_word(total));
    r.tracking_error = 32'(err);
    return r;
  endfunction

  // Sender: each word waits a random gap, and at least a quarter of the words go
  // back to back so that gaps and bursts both reach every phase of a tick.
  int in_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_words.push_back(next_control('{target, measured}));
        in_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() > 0) begin
          tick_word_t w;
          w = pending_ticks.pop_front();
          in_valid <= 1'b1;
          target <= w.target;
          measured <= w.measured;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // The long receiver hold-off runs in its own process once requested.
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      hold_count++;
      if (hold_count >= HoldCycles) hold_done = 1'b1;
    end
  end

  // Receiver: checks each accepted word against the oldest expectation.
  int out_stall = 0;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $display("unexpected word at %0t: drive %0d error %0d", $realtime, drive,
                   tracking_error);
          fail_count++;
        end else begin
          control_word_t want;
          want = expected_words.pop_front();
          if (drive !== want.drive) report_mismatch("drive", drive, want.drive);
          if (tracking_error !== want.tracking_error)
            report_mismatch("tracking_error", tracking_error, want.tracking_error);
        end
        out_stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
      end else if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("adaptive_sliding_mode_controller_top regression: fail");
      $finish;
    end
  end

  // A register write lands at one edge; the local copy follows at once since
  // writes happen only while the block is idle.
  task automatic write_reg(input logic [asmc_pkg::IndexWidth-1:0] idx,
                           input logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      asmc_pkg::REG_SURFACE_SLOPE: slope_q = val[30:0];
      asmc_pkg::REG_LINEAR_GAIN:   lin_gain_q = val[30:0];
      asmc_pkg::REG_ADAPT_STEP:    step_q = val[30:0];
      asmc_pkg::REG_GAIN_FLOOR:    floor_q = val[30:0];
      asmc_pkg::REG_SURFACE_BAND:  band_q = val[30:0];
      asmc_pkg::REG_WRAP_ENABLE:   wrap_on = val[0];
      asmc_pkg::REG_INPUT_LOW:     range_low = longint'(signed'(val));
      default:                     range_high = longint'(signed'(val));
    endcase
    kept_error = 0;
    gain_acc = 0;
  endtask

  // The unused upper bit of the 31-bit registers is driven at random.
  task automatic load_settings(input logic [30:0] slope, lin, step, floor_v, band,
                               input bit wrap, input logic [31:0] lo, hi);
    write_reg(asmc_pkg::REG_SURFACE_SLOPE, {1'($urandom), slope});
    write_reg(asmc_pkg::REG_LINEAR_GAIN, {1'($urandom), lin});
    write_reg(asmc_pkg::REG_ADAPT_STEP, {1'($urandom), step});
    write_reg(asmc_pkg::REG_GAIN_FLOOR, {1'($urandom), floor_v});
    write_reg(asmc_pkg::REG_SURFACE_BAND, {1'($urandom), band});
    write_reg(asmc_pkg::REG_WRAP_ENABLE, {31'($urandom), wrap});
    write_reg(asmc_pkg::REG_INPUT_LOW, lo);
    write_reg(asmc_pkg::REG_INPUT_HIGH, hi);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic queue_tick(input logic [31:0] tg, input logic [31:0] ms);
    pending_ticks.push_back('{tg, ms});
  endtask

  // A quarter of the ticks track a setpoint closely so the surface nears the band and the
  // gain adapts; the rest are one-bit flips, small signed words or full-range words.
  task automatic queue_random(input int count);
    logic [31:0] base;
    for (int i = 0; i < count; i++) begin
      base = $urandom;
      case ($urandom_range(0, 3))
        0: queue_tick($urandom, $urandom);
        1: queue_tick(base, base + 32'($signed($urandom_range(0, 8191)) - 4096));
        2: queue_tick(32'($signed($urandom_range(0, 800000)) - 400000),
                      32'($signed($urandom_range(0, 800000)) - 400000));
        default: queue_tick(base, base ^ (32'd1 << $urandom_range(0, 31)));
      endcase
    end
  endtask

  task automatic drain_block();
    while (pending_ticks.size() > 0 || in_valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    slope_q = asmc_pkg::SLOPE_RESET;
    lin_gain_q = 0;
    step_q = 0;
    floor_q = 0;
    band_q = 0;
    wrap_on = 1'b0;
    range_low = 0;
    range_high = 0;
    kept_error = 0;
    gain_acc = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: error extremes, zero error and single-step errors.
    queue_tick(32'h7FFF_FFFF, 32'h8000_0000);
    queue_tick(32'h8000_0000, 32'h7FFF_FFFF);
    queue_tick(32'h0, 32'h0);
    queue_tick(32'h1, 32'h0);
    queue_tick(32'h0, 32'h1);
    queue_tick(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random(60);
    drain_block();

    // Adaptive gain with a band; the receiver holds off here so the block
    // backs up and stalls its input.
    load_settings(31'd65536, 31'd32768, 31'd4096, 31'd2048, 31'd65536, 1'b0, 0, 0);
    hold_go = 1'b1;
    queue_random(110);
    drain_block();

    // Angle wrap over plus and minus pi, with folds at and near half a span.
    load_settings(31'd131072, 31'd65536, 31'd1000, 31'd100, 31'd65536, 1'b1,
                  -32'sd205887, 32'sd205887);
    queue_tick(32'sd205887, -32'sd205887);
    queue_tick(-32'sd205887, 32'sd205887);
    queue_tick(32'sd205887, 32'sd0);
    queue_tick(32'sd205888, 32'sd0);
    queue_tick(32'sd0, 32'sd205888);
    queue_tick(32'h7FFF_FFFF, 32'h8000_0000);
    queue_random(110);
    drain_block();

    // Every register at its top value and the widest range.
    load_settings(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF,
                  31'h7FFF_FFFF, 1'b1, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_tick(32'h7FFF_FFFF, 32'h8000_0000);
    queue_tick(32'h8000_0000, 32'h7FFF_FFFF);
    queue_random(100);
    drain_block();

    // Zero span: wrap enabled but no folding.
    load_settings(31'd0, 31'd0, 31'd0, 31'd0, 31'd0, 1'b1, 32'sd5, 32'sd5);
    queue_random(80);
    drain_block();

    // Negative span: wrap enabled but no folding.
    load_settings(31'($urandom), 31'($urandom_range(0, 262144)), 31'($urandom_range(0, 65536)),
                  31'($urandom_range(0, 65536)), 31'($urandom_range(0, 262144)), 1'b1,
                  32'sd100000, -32'sd100000);
    queue_random(100);
    drain_block();

    // No slope, top linear gain, zero floor and band.
    load_settings(31'd0, 31'h7FFF_FFFF, 31'd16, 31'd0, 31'd0, 1'b0, 0, 0);
    queue_random(80);
    drain_block();

    // Random settings with small random ranges.
    for (int k = 0; k < 3; k++) begin
      load_settings(31'($urandom), 31'($urandom), 31'($urandom_range(0, 100000)),
                    31'($urandom_range(0, 100000)), 31'($urandom_range(0, 400000)),
                    1'($urandom), 32'($signed($urandom_range(0, 400000)) - 300000),
                    32'($signed($urandom_range(0, 400000)) - 100000));
      queue_random(50);
      drain_block();
    end

    if (fail_count == 0) begin
      $display("adaptive_sliding_mode_controller_top regression: pass");
    end else begin
      $display("adaptive_sliding_mode_controller_top regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
